FILE: rtl/vdrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor ring manager package
// Command codes, controller states and fixed constants.
// ----------------------------------------------------------------------------
package vdrm_pkg;

  localparam logic [1:0] CMD_POST    = 2'd0;
  localparam logic [1:0] CMD_PUBLISH = 2'd1;
  localparam logic [1:0] CMD_USED    = 2'd2;

  localparam logic [15:0] KICK_GUARD = 16'h7FFF;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_POST,
    S_WALK
  } state_e;

endpackage

FILE: rtl/virtqueue_descriptor_ring_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor ring manager
// Driver side of a split virtqueue: descriptor table with LIFO free list,
// available ring, kick decision and completion handling.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// request   in         start_i and not busy_o       command_i .. used_len_i
// result    out        valid_o, one cycle           desc_index_o .. no_descriptor_o
// config    in         cfg_we_i                     cfg_wdata_i
//
// A publish, a no-op or a failed post gives its result in the cycle after
// the request. A post reads the link memory, then writes it and the
// descriptor table in S_POST. A used request frees one descriptor per step
// of its walk through the link memory. After reset a clearing pass over all
// DESC_COUNT entries initialises the free list while busy_o is high.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_ring_manager
  import vdrm_pkg::*;
#(
  parameter int DESC_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] buf_addr_i,
  input  logic [31:0] buf_len_i,
  input  logic        buf_writeable_i,
  input  logic        chain_head_i,
  input  logic [15:0] avail_evt_i,
  input  logic        device_no_notify_i,
  input  logic [7:0]  used_id_i,
  input  logic [31:0] used_len_i,
  output logic        valid_o,
  output logic [7:0]  desc_index_o,
  output logic [15:0] avail_index_o,
  output logic        kick_o,
  output logic [7:0]  done_id_o,
  output logic [31:0] done_len_o,
  output logic [8:0]  freed_count_o,
  output logic [8:0]  free_count_o,
  output logic [15:0] used_tail_o,
  output logic        no_descriptor_o
);

  localparam int IW = $clog2(DESC_COUNT);
  localparam logic [IW:0] FULL = (IW+1)'(DESC_COUNT);

  state_e        state_q, state_d;
  logic [IW-1:0] init_q, init_d;
  logic [IW-1:0] free_head_q, free_head_d;
  logic [IW:0]   free_total_q, free_total_d;
  logic [15:0]   avail_head_q, avail_head_d;
  logic [15:0]   added_q, added_d;
  logic [15:0]   used_tail_q, used_tail_d;
  logic [IW-1:0] chain_prev_q, chain_prev_d;
  logic          chain_open_q, chain_open_d;
  logic          evt_en_q;
  logic [IW-1:0] walk_id_q, walk_id_d;
  logic [IW:0]   freed_q, freed_d;

  logic [63:0]   addr_q;
  logic [31:0]   len_q;
  logic          wr_q;
  logic          head_q;
  logic [7:0]    used_id_q;
  logic [31:0]   used_len_q;

  logic          res_valid_q, res_valid_d;
  logic [7:0]    res_desc_q, res_desc_d;
  logic          res_kick_q, res_kick_d;
  logic [7:0]    res_done_id_q, res_done_id_d;
  logic [31:0]   res_done_len_q, res_done_len_d;
  logic [8:0]    res_freed_q, res_freed_d;
  logic          res_nodesc_q, res_nodesc_d;

  logic [IW:0]   link_mem [DESC_COUNT];
  logic [96:0]   desc_mem [DESC_COUNT];
  logic [IW-1:0] avail_mem [DESC_COUNT];

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW:0]   rd_data_q;
  logic          lk_we;
  logic [IW-1:0] lk_waddr;
  logic [IW:0]   lk_wdata;
  logic          dsc_we;
  logic          av_we;

  logic [IW+7:0] used_wide;
  logic [IW+7:0] d_wide;
  logic [IW+8:0] freed_wide;
  logic [IW+8:0] total_wide;
  logic [15:0]   diff;
  logic          need;
  logic          kick;
  logic [IW:0]   freed_next;

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (rd_en) begin
      if (lk_we && (lk_waddr == rd_addr)) begin
        rd_data_q <= lk_wdata;
      end else begin
        rd_data_q <= link_mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dsc_we) begin
      desc_mem[free_head_q] <= {addr_q, len_q, wr_q};
    end
    if (av_we) begin
      avail_mem[avail_head_q[IW-1:0]] <= free_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      addr_q     <= buf_addr_i;
      len_q      <= buf_len_i;
      wr_q       <= buf_writeable_i;
      head_q     <= chain_head_i;
      used_id_q  <= used_id_i;
      used_len_q <= used_len_i;
    end
  end

  always_comb begin
    used_wide  = {{IW{1'b0}}, used_id_i};
    d_wide     = {8'd0, free_head_q};
    freed_next = freed_q + 1'b1;
    freed_wide = {8'd0, freed_next};
    total_wide = {8'd0, free_total_q};
    diff       = avail_head_q - avail_evt_i - 16'd1;
    need       = diff < added_q;
    if (evt_en_q) begin
      kick = need || (added_q >= KICK_GUARD);
    end else begin
      kick = !device_no_notify_i;
    end
  end

  always_comb begin
    state_d        = state_q;
    init_d         = init_q;
    free_head_d    = free_head_q;
    free_total_d   = free_total_q;
    avail_head_d   = avail_head_q;
    added_d        = added_q;
    used_tail_d    = used_tail_q;
    chain_prev_d   = chain_prev_q;
    chain_open_d   = chain_open_q;
    walk_id_d      = walk_id_q;
    freed_d        = freed_q;
    res_valid_d    = 1'b0;
    res_desc_d     = 8'd0;
    res_kick_d     = 1'b0;
    res_done_id_d  = 8'd0;
    res_done_len_d = 32'd0;
    res_freed_d    = 9'd0;
    res_nodesc_d   = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = free_head_q;
    lk_we          = 1'b0;
    lk_waddr       = free_head_q;
    lk_wdata       = '0;
    dsc_we         = 1'b0;
    av_we          = 1'b0;
    case (state_q)
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = init_q;
        lk_wdata = {1'b0, init_q - 1'b1};
        init_d   = init_q + 1'b1;
        if (init_q == IW'(DESC_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          case (command_i)
            CMD_POST: begin
              if (free_total_q == '0) begin
                res_valid_d  = 1'b1;
                res_nodesc_d = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = free_head_q;
                state_d = S_POST;
              end
            end
            CMD_PUBLISH: begin
              res_valid_d = 1'b1;
              res_kick_d  = kick;
              if (kick) begin
                added_d = 16'd0;
              end
            end
            CMD_USED: begin
              used_tail_d = used_tail_q + 16'd1;
              if (free_total_q == FULL) begin
                res_valid_d    = 1'b1;
                res_done_id_d  = used_id_i;
                res_done_len_d = used_len_i;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = used_wide[IW-1:0];
                walk_id_d = used_wide[IW-1:0];
                freed_d   = '0;
                state_d   = S_WALK;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POST: begin
        free_head_d  = rd_data_q[IW-1:0];
        free_total_d = free_total_q - 1'b1;
        lk_we        = 1'b1;
        lk_waddr     = free_head_q;
        lk_wdata     = {chain_open_q, chain_open_q ? chain_prev_q : {IW{1'b0}}};
        dsc_we       = 1'b1;
        if (head_q) begin
          av_we        = 1'b1;
          avail_head_d = avail_head_q + 16'd1;
          added_d      = added_q + 16'd1;
          chain_open_d = 1'b0;
          chain_prev_d = '0;
        end else begin
          chain_open_d = 1'b1;
          chain_prev_d = free_head_q;
        end
        res_valid_d = 1'b1;
        res_desc_d  = d_wide[7:0];
        state_d     = S_IDLE;
      end
      S_WALK: begin
        lk_we        = 1'b1;
        lk_waddr     = walk_id_q;
        lk_wdata     = {rd_data_q[IW], free_head_q};
        free_head_d  = walk_id_q;
        free_total_d = free_total_q + 1'b1;
        freed_d      = freed_next;
        if (rd_data_q[IW] && (free_total_d != FULL)) begin
          rd_en     = 1'b1;
          rd_addr   = rd_data_q[IW-1:0];
          walk_id_d = rd_data_q[IW-1:0];
        end else begin
          res_valid_d    = 1'b1;
          res_done_id_d  = used_id_q;
          res_done_len_d = used_len_q;
          res_freed_d    = freed_wide[8:0];
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      init_q       <= '0;
      free_head_q  <= IW'(DESC_COUNT - 1);
      free_total_q <= FULL;
      avail_head_q <= 16'd0;
      added_q      <= 16'd0;
      used_tail_q  <= 16'd0;
      chain_prev_q <= '0;
      chain_open_q <= 1'b0;
      evt_en_q     <= 1'b1;
      walk_id_q    <= '0;
      freed_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      free_head_q  <= free_head_d;
      free_total_q <= free_total_d;
      avail_head_q <= avail_head_d;
      added_q      <= added_d;
      used_tail_q  <= used_tail_d;
      chain_prev_q <= chain_prev_d;
      chain_open_q <= chain_open_d;
      walk_id_q    <= walk_id_d;
      freed_q      <= freed_d;
      res_valid_q  <= res_valid_d;
      if (cfg_we_i) begin
        evt_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_desc_q     <= res_desc_d;
    res_kick_q     <= res_kick_d;
    res_done_id_q  <= res_done_id_d;
    res_done_len_q <= res_done_len_d;
    res_freed_q    <= res_freed_d;
    res_nodesc_q   <= res_nodesc_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = res_valid_q;
  assign desc_index_o    = res_desc_q;
  assign avail_index_o   = avail_head_q;
  assign kick_o          = res_kick_q;
  assign done_id_o       = res_done_id_q;
  assign done_len_o      = res_done_len_q;
  assign freed_count_o   = res_freed_q;
  assign free_count_o    = total_wide[8:0];
  assign used_tail_o     = used_tail_q;
  assign no_descriptor_o = res_nodesc_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= FULL) else $error("free descriptor count above ring size");
  a_post_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POST) |=> valid_o) else $error("post gave no result");
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !valid_o) else $error("result during clearing pass");
`endif

endmodule
